// File: rtl/backpressure_level_admission_assert.svh
// Assertion macros for the backpressure level admission block.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef BACKPRESSURE_LEVEL_ADMISSION_ASSERT_SVH
`define BACKPRESSURE_LEVEL_ADMISSION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bla_pkg.sv
// Shared types and constants for the backpressure level admission block.
// No dependencies.
`timescale 1ns / 1ps

package bla_pkg;

   localparam int CAP_WIDTH = 20;
   localparam int PCT_WIDTH = 7;
   localparam int OUT_COUNT_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CAP_WIDTH-1:0] CAP_DEFAULT = 20'd10000;
   localparam logic [PCT_WIDTH-1:0] SLOW_DEFAULT = 7'd80;
   localparam logic [PCT_WIDTH-1:0] DROP_DEFAULT = 7'd90;
   localparam logic [PCT_WIDTH-1:0] REJECT_DEFAULT = 7'd95;
   localparam logic [PCT_WIDTH-1:0] RECOVER_DEFAULT = 7'd60;

   // opcodes
   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_SEND = 2'd1;
   localparam logic [1:0] OP_CONNECT = 2'd2;

   // levels
   localparam logic [1:0] LVL_NORMAL = 2'd0;
   localparam logic [1:0] LVL_SLOW = 2'd1;
   localparam logic [1:0] LVL_DROP = 2'd2;
   localparam logic [1:0] LVL_REJECT = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_CAPACITY = 3'd0;
   localparam logic [2:0] REG_SLOW = 3'd1;
   localparam logic [2:0] REG_DROP = 3'd2;
   localparam logic [2:0] REG_REJECT = 3'd3;
   localparam logic [2:0] REG_RECOVER = 3'd4;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: rtl/bla_divider.sv
// Restoring divider, one quotient bit per cycle, for the fill percentage.
// Depends on bla_pkg.
`timescale 1ns / 1ps

module bla_divider #(
   parameter int NUM_WIDTH = 27
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [NUM_WIDTH-1:0]           dividend,
   input  logic [bla_pkg::CAP_WIDTH-1:0]  divisor,
   output logic [NUM_WIDTH-1:0]           quotient,
   output bla_pkg::div_status_type        status
);

   localparam int CW = bla_pkg::CAP_WIDTH;
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [CW-1:0]        div_ff, div_in;

   logic [CW:0]   shifted;
   logic [CW+1:0] diff;
   logic          fits;

   // one trial subtraction a cycle
   assign shifted = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign fits    = !diff[CW+1];

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         cnt_in = CNT_WIDTH'(NUM_WIDTH);
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_WIDTH'(1));
         quo_in  = {quo_ff[NUM_WIDTH-2:0], fits};
         rem_in  = fits ? diff[CW-1:0] : shifted[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

// File: rtl/backpressure_level_admission.sv
// Top level of the four-level queue backpressure controller with hysteresis.
// Depends on bla_pkg, bla_divider and backpressure_level_admission_assert.svh.
//
//  channel | dir | handshake            | carries
//  --------+-----+----------------------+---------------------------------------
//  req_    | in  | tvalid/tready        | opcode, depth, droppable
//  rsp_    | out | tvalid/tready        | level, allowed, five counters, depth
//  csr_    | in  | psel/penable, pready | capacity and four percent thresholds
//
// A depth update offers its result beat once the serial divider, which yields
// one quotient bit a cycle, has finished; no new beat is taken until then.
// Send queries, connection requests and the unused opcode offer their result
// beat in the cycle after they are taken. The result beat sits in an output
// register; the next beat is taken in the cycle the result leaves. Reset is
// synchronous and restores the registers to their defaults and all counters
// and the level to zero.
`timescale 1ns / 1ps

module backpressure_level_admission #(
   parameter int DEPTH_WIDTH = 20,
   parameter int COUNT_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,

   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // depth (DEPTH_WIDTH bits), zero padded to whole bytes
   input  logic [((DEPTH_WIDTH+7)/8)*8-1:0]         req_tdata,
   // opcode [1:0], droppable [2]
   input  logic [2:0]                               req_tuser,

   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // level [1:0], allowed, sent, dropped, rejected, raise, recover counts
   // (32 bits each), last_depth (DEPTH_WIDTH bits), zero padded to bytes
   output logic [((DEPTH_WIDTH+163+7)/8)*8-1:0]     rsp_tdata,

   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [bla_pkg::CSR_ADDR_WIDTH-1:0]       csr_paddr,
   input  logic [bla_pkg::CSR_DATA_WIDTH-1:0]       csr_pwdata,
   output logic [bla_pkg::CSR_DATA_WIDTH-1:0]       csr_prdata,
   output logic                                     csr_pready
);

   `include "backpressure_level_admission_assert.svh"

   localparam int NUM_WIDTH = DEPTH_WIDTH + 7;
   localparam int OUT_BITS = DEPTH_WIDTH + 163;
   localparam int OUT_PAD = ((OUT_BITS + 7) / 8) * 8 - OUT_BITS;
   localparam int CW = bla_pkg::CAP_WIDTH;
   localparam int PW = bla_pkg::PCT_WIDTH;
   localparam int OCW = bla_pkg::OUT_COUNT_WIDTH;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   // --- configuration registers ----------------------------------------
   logic [CW-1:0] capacity_ff;
   logic [PW-1:0] slow_ff, drop_ff, reject_ff, recover_ff;
   logic          csr_write;
   logic [2:0]    csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bla_pkg::CAP_DEFAULT;
         slow_ff     <= bla_pkg::SLOW_DEFAULT;
         drop_ff     <= bla_pkg::DROP_DEFAULT;
         reject_ff   <= bla_pkg::REJECT_DEFAULT;
         recover_ff  <= bla_pkg::RECOVER_DEFAULT;
      end else if (csr_write) begin
         unique case (csr_index)
            bla_pkg::REG_CAPACITY: capacity_ff <= csr_pwdata[CW-1:0];
            bla_pkg::REG_SLOW:     slow_ff     <= csr_pwdata[PW-1:0];
            bla_pkg::REG_DROP:     drop_ff     <= csr_pwdata[PW-1:0];
            bla_pkg::REG_REJECT:   reject_ff   <= csr_pwdata[PW-1:0];
            bla_pkg::REG_RECOVER:  recover_ff  <= csr_pwdata[PW-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bla_pkg::REG_CAPACITY: csr_prdata = 32'(capacity_ff);
         bla_pkg::REG_SLOW:     csr_prdata = 32'(slow_ff);
         bla_pkg::REG_DROP:     csr_prdata = 32'(drop_ff);
         bla_pkg::REG_REJECT:   csr_prdata = 32'(reject_ff);
         bla_pkg::REG_RECOVER:  csr_prdata = 32'(recover_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // --- request fields -----------------------------------------------------
   logic [1:0]             req_opcode;
   logic [DEPTH_WIDTH-1:0] req_depth;
   logic                   req_droppable;

   assign req_opcode    = req_tuser[1:0];
   assign req_droppable = req_tuser[2];
   assign req_depth     = req_tdata[DEPTH_WIDTH-1:0];

   // --- sequencer and block state ------------------------------------------
   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   allowed_ff, allowed_in;
   logic [1:0]             level_ff, level_in;
   logic [DEPTH_WIDTH-1:0] depth_ff, depth_in;
   logic [COUNT_WIDTH-1:0] sent_ff, sent_in;
   logic [COUNT_WIDTH-1:0] dropped_ff, dropped_in;
   logic [COUNT_WIDTH-1:0] rejected_ff, rejected_in;
   logic [COUNT_WIDTH-1:0] raise_ff, raise_in;
   logic [COUNT_WIDTH-1:0] recover_cnt_ff, recover_cnt_in;

   logic                   accept;
   logic                   out_free;
   logic                   div_start;
   logic [NUM_WIDTH-1:0]   dividend;
   logic [CW-1:0]          divisor;
   logic [NUM_WIDTH-1:0]   pct;
   bla_pkg::div_status_type div_stat;
   logic [1:0]             target;

   // take a beat only when idle and the result register is empty or leaving
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign div_start  = accept && (req_opcode == bla_pkg::OP_UPDATE);

   // depth * 100 as three shifted adds; zero capacity falls back to default
   assign dividend = (NUM_WIDTH'(req_depth) << 6) + (NUM_WIDTH'(req_depth) << 5)
                   + (NUM_WIDTH'(req_depth) << 2);
   assign divisor  = (capacity_ff == '0) ? bla_pkg::CAP_DEFAULT : capacity_ff;

   bla_divider #(
      .NUM_WIDTH(NUM_WIDTH)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(dividend),
      .divisor (divisor),
      .quotient(pct),
      .status  (div_stat)
   );

   // target level: reject tested first, then drop, then slow
   always_comb begin
      if (pct >= NUM_WIDTH'(reject_ff)) begin
         target = bla_pkg::LVL_REJECT;
      end else if (pct >= NUM_WIDTH'(drop_ff)) begin
         target = bla_pkg::LVL_DROP;
      end else if (pct >= NUM_WIDTH'(slow_ff)) begin
         target = bla_pkg::LVL_SLOW;
      end else begin
         target = bla_pkg::LVL_NORMAL;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      allowed_in     = allowed_ff;
      level_in       = level_ff;
      depth_in       = depth_ff;
      sent_in        = sent_ff;
      dropped_in     = dropped_ff;
      rejected_in    = rejected_ff;
      raise_in       = raise_ff;
      recover_cnt_in = recover_cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               allowed_in = 1'b1;
               case (req_opcode)
                  bla_pkg::OP_UPDATE: begin
                     // hold the beat until the quotient is in
                     depth_in     = req_depth;
                     rsp_valid_in = 1'b0;
                     state_in     = ST_DIVIDE;
                  end
                  bla_pkg::OP_SEND: begin
                     rsp_valid_in = 1'b1;
                     if (level_ff >= bla_pkg::LVL_DROP && req_droppable) begin
                        allowed_in = 1'b0;
                        dropped_in = dropped_ff + 1'b1;
                     end else begin
                        sent_in = sent_ff + 1'b1;
                     end
                  end
                  bla_pkg::OP_CONNECT: begin
                     rsp_valid_in = 1'b1;
                     if (level_ff == bla_pkg::LVL_REJECT) begin
                        allowed_in  = 1'b0;
                        rejected_in = rejected_ff + 1'b1;
                     end
                  end
                  default: begin
                     // unused opcode: report state with allowed set, change nothing else
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (target > level_ff) begin
                  // raise at once
                  level_in = target;
                  raise_in = raise_ff + 1'b1;
               end else if (target < level_ff && pct <= NUM_WIDTH'(recover_ff)) begin
                  // lower only once the fill has fallen to the recover mark
                  level_in       = target;
                  recover_cnt_in = recover_cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         allowed_ff     <= 1'b1;
         level_ff       <= bla_pkg::LVL_NORMAL;
         depth_ff       <= '0;
         sent_ff        <= '0;
         dropped_ff     <= '0;
         rejected_ff    <= '0;
         raise_ff       <= '0;
         recover_cnt_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         allowed_ff     <= allowed_in;
         level_ff       <= level_in;
         depth_ff       <= depth_in;
         sent_ff        <= sent_in;
         dropped_ff     <= dropped_in;
         rejected_ff    <= rejected_in;
         raise_ff       <= raise_in;
         recover_cnt_ff <= recover_cnt_in;
      end
   end

   // --- result beat ----------------------------------------------------------
   // The state only moves when the next beat is taken or its division ends, and
   // both need the result register free, so the live state is the pending result.
   logic [63:0] sent_x, dropped_x, rejected_x, raise_x, recover_x;

   assign sent_x     = 64'(sent_ff);
   assign dropped_x  = 64'(dropped_ff);
   assign rejected_x = 64'(rejected_ff);
   assign raise_x    = 64'(raise_ff);
   assign recover_x  = 64'(recover_cnt_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{OUT_PAD{1'b0}}, depth_ff, recover_x[OCW-1:0], raise_x[OCW-1:0],
                        rejected_x[OCW-1:0], dropped_x[OCW-1:0], sent_x[OCW-1:0],
                        allowed_ff, level_ff};

   // --- checks ---------------------------------------------------------------
   `BLA_ASSERT_NOW(a_no_take_while_dividing, div_stat.busy || state_ff == ST_DIVIDE, !req_tready, "beat taken while the divider is at work")
   `BLA_ASSERT_NOW(a_done_only_in_divide, div_stat.done, state_ff == ST_DIVIDE, "divider finished outside a depth update")
   `BLA_ASSERT_NOW(a_raise_counted, !$past(reset) && level_ff > $past(level_ff), raise_ff == COUNT_WIDTH'($past(raise_ff) + 1'b1), "level rose without a raise count")
   `BLA_ASSERT_NEXT(a_update_waits, div_start, state_ff == ST_DIVIDE && !rsp_tvalid, "depth update result shown before the quotient")

endmodule
